// ----- hdl/dcm_pkg.sv -----
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types, codes and fixed widths for the DC motor command block.
// ----------------------------------------------------------------------------
package dcm_pkg;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int REQ_W   = 16;
    localparam int NOW_W   = 32;
    localparam int DRIVE_W = 9;
    localparam int MODE_W  = 2;
    localparam int STEP_W  = 7;
    localparam int CUT_W   = 10;
    localparam int WAIT_W  = 8;

    // APB register file
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SPEED_STEP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_CUT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_CUT   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WAIT_MS    = 2'd3;

    localparam logic [STEP_W-1:0] RST_SPEED_STEP = 7'd10;
    localparam logic [CUT_W-1:0]  RST_LOW_CUT    = 10'd200;
    localparam logic [CUT_W-1:0]  RST_HIGH_CUT   = 10'd950;
    localparam logic [WAIT_W-1:0] RST_WAIT_MS    = 8'd2;

    // Drive values: inverted, full drive is zero
    localparam logic [DRIVE_W-1:0] DRIVE_OFF  = 9'd500;
    localparam logic [DRIVE_W-1:0] DRIVE_FULL = 9'd0;

    // Command opcodes
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_SET_SPEED  = 3'd1,
        OP_ACCEL      = 3'd2,
        OP_SLOW       = 3'd3,
        OP_STOP       = 3'd4,
        OP_RUN        = 3'd5,
        OP_SET_DIR    = 3'd6,
        OP_TOGGLE_DIR = 3'd7
    } op_t;

    // Mode codes as reported on the result channel
    localparam logic [MODE_W-1:0] MODE_RUNNING  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT_OFF = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WAIT_DIR = 2'd3;

    // Motor mode state machine
    typedef enum logic [3:0] {
        ST_RUNNING  = 4'b0001,
        ST_OFF      = 4'b0010,
        ST_WAIT_OFF = 4'b0100,
        ST_WAIT_DIR = 4'b1000
    } mode_state_t;

    // Configuration register set
    typedef struct packed {
        logic [STEP_W-1:0] speed_step;
        logic [CUT_W-1:0]  low_cut;
        logic [CUT_W-1:0]  high_cut;
        logic [WAIT_W-1:0] wait_ms;
    } cfg_t;

    function automatic logic [MODE_W-1:0] mode_code(mode_state_t st);
        logic [MODE_W-1:0] code;
        case (st)
            ST_RUNNING:  code = MODE_RUNNING;
            ST_OFF:      code = MODE_OFF;
            ST_WAIT_OFF: code = MODE_WAIT_OFF;
            ST_WAIT_DIR: code = MODE_WAIT_DIR;
            default:     code = MODE_RUNNING;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/dcm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// dcm_cmd_if
// Command channel: valid/ready handshake carrying one motor command per beat.
// ----------------------------------------------------------------------------
interface dcm_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dcm_pkg::OP_W-1:0]      op;
    logic [dcm_pkg::REQ_W-1:0]     speed_value;
    logic                          dir_value;
    logic [dcm_pkg::NOW_W-1:0]     now_ms;

    modport source (output valid, op, speed_value, dir_value, now_ms, input ready);
    modport sink   (input valid, op, speed_value, dir_value, now_ms, output ready);
endinterface

// ----- hdl/dcm_res_if.sv -----
// ----------------------------------------------------------------------------
// dcm_res_if
// Result channel: valid/ready handshake carrying one drive result per beat.
// ----------------------------------------------------------------------------
interface dcm_res_if #(
    parameter int SPEED_W = 10
);
    logic                          valid;
    logic                          ready;
    logic                          speed_write;
    logic [dcm_pkg::DRIVE_W-1:0]   speed_drive;
    logic                          dir_write;
    logic                          dir_drive;
    logic [dcm_pkg::MODE_W-1:0]    motor_mode;
    logic [SPEED_W-1:0]            speed_setting;

    modport source (output valid, speed_write, speed_drive, dir_write, dir_drive,
                    motor_mode, speed_setting, input ready);
    modport sink   (input valid, speed_write, speed_drive, dir_write, dir_drive,
                    motor_mode, speed_setting, output ready);
endinterface

// ----- hdl/dcm_apb_regs.sv -----
// ----------------------------------------------------------------------------
// dcm_apb_regs
// APB register file holding step size, cut-offs and reversal wait.
// ----------------------------------------------------------------------------
module dcm_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dcm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dcm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dcm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output dcm_pkg::cfg_t                   cfg
);

    dcm_pkg::cfg_t                  cfg_reg;
    dcm_pkg::cfg_t                  cfg_next;
    logic                           wr_en;
    logic [dcm_pkg::REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[dcm_pkg::APB_ADDR_W-1:2];

    // Decode the write beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                dcm_pkg::REG_SPEED_STEP: cfg_next.speed_step = pwdata[dcm_pkg::STEP_W-1:0];
                dcm_pkg::REG_LOW_CUT:    cfg_next.low_cut    = pwdata[dcm_pkg::CUT_W-1:0];
                dcm_pkg::REG_HIGH_CUT:   cfg_next.high_cut   = pwdata[dcm_pkg::CUT_W-1:0];
                dcm_pkg::REG_WAIT_MS:    cfg_next.wait_ms    = pwdata[dcm_pkg::WAIT_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_step <= dcm_pkg::RST_SPEED_STEP;
            cfg_reg.low_cut    <= dcm_pkg::RST_LOW_CUT;
            cfg_reg.high_cut   <= dcm_pkg::RST_HIGH_CUT;
            cfg_reg.wait_ms    <= dcm_pkg::RST_WAIT_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back, zero extended
    always_comb
    begin
        case (reg_idx)
            dcm_pkg::REG_SPEED_STEP: prdata = dcm_pkg::APB_DATA_W'(cfg_reg.speed_step);
            dcm_pkg::REG_LOW_CUT:    prdata = dcm_pkg::APB_DATA_W'(cfg_reg.low_cut);
            dcm_pkg::REG_HIGH_CUT:   prdata = dcm_pkg::APB_DATA_W'(cfg_reg.high_cut);
            dcm_pkg::REG_WAIT_MS:    prdata = dcm_pkg::APB_DATA_W'(cfg_reg.wait_ms);
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/dcm_drive_map.sv -----
// ----------------------------------------------------------------------------
// dcm_drive_map
// Map a speed setting to the inverted drive value with low/high cut-offs.
// ----------------------------------------------------------------------------
module dcm_drive_map #(
    parameter int FULL_SCALE = 1000,
    parameter int SPEED_W    = 10
) (
    input  logic [SPEED_W-1:0]            speed,
    input  logic [dcm_pkg::CUT_W-1:0]     low_cut,
    input  logic [dcm_pkg::CUT_W-1:0]     high_cut,
    output logic [dcm_pkg::DRIVE_W-1:0]   drive
);

    // floor(500 * s / FULL_SCALE) as s * K >> RECIP_SH; exact while s * FULL_SCALE < 2^24
    localparam int          RECIP_SH = 24;
    localparam longint      RECIP_K  =
        ((longint'(500) << RECIP_SH) + longint'(FULL_SCALE) - 1) / longint'(FULL_SCALE);
    localparam int          K_W      = $clog2(RECIP_K + 1);
    localparam int          PROD_W   = SPEED_W + K_W;
    localparam int          CMP_W    = (SPEED_W > dcm_pkg::CUT_W) ? SPEED_W : dcm_pkg::CUT_W;
    localparam logic [K_W-1:0] RECIP  = K_W'(RECIP_K);

    logic [PROD_W-1:0]           prod;
    logic [dcm_pkg::DRIVE_W-1:0] quo;
    logic [CMP_W-1:0]            spd_ext;
    logic [CMP_W-1:0]            low_ext;
    logic [CMP_W-1:0]            high_ext;

    assign prod     = PROD_W'(speed) * PROD_W'(RECIP);
    assign quo      = prod[RECIP_SH +: dcm_pkg::DRIVE_W];
    assign spd_ext  = CMP_W'(speed);
    assign low_ext  = CMP_W'(low_cut);
    assign high_ext = CMP_W'(high_cut);

    // High cut-off wins over low cut-off
    always_comb
    begin
        if (spd_ext > high_ext)
            drive = dcm_pkg::DRIVE_FULL;
        else if (spd_ext < low_ext)
            drive = dcm_pkg::DRIVE_OFF;
        else
            drive = dcm_pkg::DRIVE_OFF - quo;
    end

endmodule

// ----- hdl/dc_motor_speed_reversal_control_top.sv -----
// ----------------------------------------------------------------------------
// dc_motor_speed_reversal_control_top
// Flow: an accepted command beat is held in the command register, then its
// result is registered in the result register and offered as a result beat.
// Throughput: one command per cycle while results drain; a stalled result
// holds the command register, so one more command enters and then ready drops.
// Reset: asynchronous, active low; mode running, speed 0, update pending, run
// enabled, direction 0, timestamp 0, registers at their documented defaults.
// ----------------------------------------------------------------------------
module dc_motor_speed_reversal_control_top #(
    parameter int FULL_SCALE = 1000,
    parameter int TIME_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dcm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dcm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dcm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    dcm_cmd_if.sink                         cmd,
    dcm_res_if.source                       res
);

    localparam int SPEED_W = $clog2(FULL_SCALE + 1);
    localparam logic [SPEED_W-1:0]          FULL_LVL = SPEED_W'(FULL_SCALE);
    localparam logic [dcm_pkg::REQ_W-1:0]   FULL_REQ = dcm_pkg::REQ_W'(FULL_SCALE);

    dcm_pkg::cfg_t cfg;

    dcm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input stage
    logic                           in_vld_reg;
    logic                           in_vld_next;
    logic [dcm_pkg::OP_W-1:0]       op_reg;
    logic [dcm_pkg::REQ_W-1:0]      req_reg;
    logic                           dreq_reg;
    logic [TIME_BITS-1:0]           now_reg;
    logic                           cmd_take;
    logic                           adv;

    // Motor state
    dcm_pkg::mode_state_t           mode_reg;
    dcm_pkg::mode_state_t           mode_next;
    logic [SPEED_W-1:0]             level_reg;
    logic [SPEED_W-1:0]             level_next;
    logic                           pend_reg;
    logic                           pend_next;
    logic                           run_reg;
    logic                           run_next;
    logic                           dir_reg;
    logic                           dir_next;
    logic [TIME_BITS-1:0]           wstart_reg;
    logic [TIME_BITS-1:0]           wstart_next;

    // Result stage
    logic                           out_vld_reg;
    logic                           out_vld_next;
    logic                           sw_reg;
    logic                           sw_next;
    logic [dcm_pkg::DRIVE_W-1:0]    sd_reg;
    logic [dcm_pkg::DRIVE_W-1:0]    sd_next;
    logic                           dw_reg;
    logic                           dw_next;
    logic                           dd_reg;
    logic                           dd_next;
    logic [dcm_pkg::MODE_W-1:0]     mcode_reg;
    logic [SPEED_W-1:0]             lvl_out_reg;

    // Datapath helpers
    logic [dcm_pkg::DRIVE_W-1:0]    drive_cur;
    logic [TIME_BITS-1:0]           elapsed;
    logic                           wait_done;
    logic [SPEED_W:0]               acc_sum;
    logic [SPEED_W-1:0]             step_ext;
    logic                           dreq_eff;

    dcm_drive_map #(
        .FULL_SCALE (FULL_SCALE),
        .SPEED_W    (SPEED_W)
    ) u_map (
        .speed    (level_reg),
        .low_cut  (cfg.low_cut),
        .high_cut (cfg.high_cut),
        .drive    (drive_cur)
    );

    // Advance a held command when the result register is free or being drained
    assign adv       = in_vld_reg && (!out_vld_reg || res.ready);
    assign cmd.ready = !in_vld_reg || adv;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        if (cmd_take)
            in_vld_next = 1'b1;
        else if (adv)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        if (adv)
            out_vld_next = 1'b1;
        else if (res.ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    assign elapsed   = now_reg - wstart_reg;
    assign wait_done = elapsed > TIME_BITS'(cfg.wait_ms);
    assign step_ext  = SPEED_W'(cfg.speed_step);
    assign acc_sum   = {1'b0, level_reg} + (SPEED_W + 1)'(cfg.speed_step);
    assign dreq_eff  = (dcm_pkg::op_t'(op_reg) == dcm_pkg::OP_TOGGLE_DIR) ? ~dir_reg : dreq_reg;

    // Command execution
    always_comb
    begin
        mode_next   = mode_reg;
        level_next  = level_reg;
        pend_next   = pend_reg;
        run_next    = run_reg;
        dir_next    = dir_reg;
        wstart_next = wstart_reg;
        sw_next     = 1'b0;
        sd_next     = '0;
        dw_next     = 1'b0;
        dd_next     = 1'b0;

        case (dcm_pkg::op_t'(op_reg))
            dcm_pkg::OP_TICK:
            begin
                case (mode_reg)
                    dcm_pkg::ST_RUNNING:
                    begin
                        if (!run_reg)
                        begin
                            sw_next   = 1'b1;
                            sd_next   = dcm_pkg::DRIVE_OFF;
                            mode_next = dcm_pkg::ST_OFF;
                        end
                        else if (pend_reg)
                        begin
                            pend_next = 1'b0;
                            sw_next   = 1'b1;
                            sd_next   = drive_cur;
                        end
                    end
                    dcm_pkg::ST_OFF:
                    begin
                        if (run_reg)
                        begin
                            sw_next   = 1'b1;
                            sd_next   = drive_cur;
                            mode_next = dcm_pkg::ST_RUNNING;
                        end
                    end
                    dcm_pkg::ST_WAIT_OFF:
                    begin
                        if (wait_done)
                        begin
                            dw_next     = 1'b1;
                            dd_next     = dir_reg;
                            wstart_next = now_reg;
                            mode_next   = dcm_pkg::ST_WAIT_DIR;
                        end
                    end
                    dcm_pkg::ST_WAIT_DIR:
                    begin
                        if (wait_done)
                            mode_next = dcm_pkg::ST_OFF;
                    end
                    default:
                    begin
                        mode_next = dcm_pkg::ST_RUNNING;
                    end
                endcase
            end
            dcm_pkg::OP_SET_SPEED:
            begin
                // Raw request compared, then clamped
                if (dcm_pkg::REQ_W'(level_reg) != req_reg)
                begin
                    level_next = (req_reg > FULL_REQ) ? FULL_LVL : req_reg[SPEED_W-1:0];
                    pend_next  = 1'b1;
                end
            end
            dcm_pkg::OP_ACCEL:
            begin
                if (level_reg < FULL_LVL)
                begin
                    level_next = (acc_sum > {1'b0, FULL_LVL}) ? FULL_LVL : acc_sum[SPEED_W-1:0];
                    pend_next  = 1'b1;
                end
            end
            dcm_pkg::OP_SLOW:
            begin
                if (level_reg != '0)
                begin
                    level_next = (level_reg > step_ext) ? (level_reg - step_ext) : '0;
                    pend_next  = 1'b1;
                end
            end
            dcm_pkg::OP_STOP:
            begin
                run_next = 1'b0;
            end
            dcm_pkg::OP_RUN:
            begin
                run_next = 1'b1;
            end
            dcm_pkg::OP_SET_DIR,
            dcm_pkg::OP_TOGGLE_DIR:
            begin
                // Reversal: drive off now, restart the wait
                if (dreq_eff != dir_reg)
                begin
                    sw_next     = 1'b1;
                    sd_next     = dcm_pkg::DRIVE_OFF;
                    mode_next   = dcm_pkg::ST_WAIT_OFF;
                    dir_next    = dreq_eff;
                    wstart_next = now_reg;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mode_reg    <= dcm_pkg::ST_RUNNING;
            level_reg   <= '0;
            pend_reg    <= 1'b1;
            run_reg     <= 1'b1;
            dir_reg     <= 1'b0;
            wstart_reg  <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (adv)
            begin
                mode_reg   <= mode_next;
                level_reg  <= level_next;
                pend_reg   <= pend_next;
                run_reg    <= run_next;
                dir_reg    <= dir_next;
                wstart_reg <= wstart_next;
            end
        end
    end

    // Capture the command beat
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg   <= cmd.op;
            req_reg  <= cmd.speed_value;
            dreq_reg <= cmd.dir_value;
            now_reg  <= cmd.now_ms[TIME_BITS-1:0];
        end
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sw_reg      <= sw_next;
            sd_reg      <= sd_next;
            dw_reg      <= dw_next;
            dd_reg      <= dd_next;
            mcode_reg   <= dcm_pkg::mode_code(mode_next);
            lvl_out_reg <= level_next;
        end
    end

    assign res.valid         = out_vld_reg;
    assign res.speed_write   = sw_reg;
    assign res.speed_drive   = sd_reg;
    assign res.dir_write     = dw_reg;
    assign res.dir_drive     = dd_reg;
    assign res.motor_mode    = mcode_reg;
    assign res.speed_setting = lvl_out_reg;

`ifndef ASSERT_OFF
    // Speed setting never leaves its range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= FULL_LVL)
        else $error("speed setting above full scale");

    // A beat never writes both the drive and the direction
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(sw_reg && dw_reg))
        else $error("drive and direction written in one beat");

    // A direction write always enters the direction wait
    a_dir_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && dw_reg |-> mcode_reg == dcm_pkg::MODE_WAIT_DIR)
        else $error("direction write outside the direction wait");

    // Drive value stays within the off level
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && sw_reg |-> sd_reg <= dcm_pkg::DRIVE_OFF)
        else $error("drive value out of range");

    // A held command beat keeps the state untouched
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !adv |=> $stable(level_reg) && $stable(mode_reg) && in_vld_reg)
        else $error("state changed while the command beat was held");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DC motor command block. Commands go in over the
// command channel in random bursts, results are taken with a random stall
// pattern, and every result beat is compared with a local motor model or a
// fixed table row. A short directed table runs first, then several random
// phases, each under its own register setting, written over APB while idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FULL_SCALE  = 1000;
    localparam int TIME_BITS   = 32;
    localparam int PHASE_CMDS  = 160;
    localparam int NUM_PHASES  = 7;
    localparam int LONG_HOLD   = 250;
    localparam int MAX_GAP     = 8;
    localparam int MAX_BURST   = 30;
    localparam longint LIMIT_NS = 2_000_000;

    // Receiver stall styles
    localparam int SINK_OPEN   = 0;
    localparam int SINK_MOSTLY = 1;
    localparam int SINK_SPARSE = 2;
    localparam int SINK_TOGGLE = 3;

    typedef struct packed {
        dcm_pkg::op_t              op;
        logic [dcm_pkg::REQ_W-1:0] speed_value;
        logic                      dir_value;
        logic [dcm_pkg::NOW_W-1:0] now_ms;
    } motor_cmd_t;

    typedef struct packed {
        logic                        speed_write;
        logic [dcm_pkg::DRIVE_W-1:0] speed_drive;
        logic                        dir_write;
        logic                        dir_drive;
        logic [dcm_pkg::MODE_W-1:0]  motor_mode;
        logic [9:0]                  speed_setting;
    } drive_res_t;

    typedef struct {
        motor_cmd_t cmd;
        bit         fixed;
        drive_res_t res;
    } cmd_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [dcm_pkg::APB_ADDR_W-1:0] paddr;
    logic [dcm_pkg::APB_DATA_W-1:0] pwdata;
    logic [dcm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    dcm_cmd_if                 cmd ();
    dcm_res_if #(.SPEED_W(10)) res ();

    dc_motor_speed_reversal_control_top #(
        .FULL_SCALE (FULL_SCALE),
        .TIME_BITS  (TIME_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd),
        .res     (res)
    );

    // Motor model state and register shadow
    dcm_pkg::cfg_t              cfg;
    logic [dcm_pkg::MODE_W-1:0] mot_mode;
    logic [9:0]                 speed_level;
    logic                       upd_pending;
    logic                       run_en;
    logic                       direction;
    logic [dcm_pkg::NOW_W-1:0]  wait_start;
    logic [dcm_pkg::NOW_W-1:0]  ms_clock;

    drive_res_t drive_q[$];
    cmd_row_t   cmd_table[$];
    int         mismatches;
    int         holds_asked;
    int         holds_taken;
    int         burst_left;
    bit         gapless;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Global time limit
    initial
    begin
        #(LIMIT_NS);
        $display("dc_motor_speed_reversal_control_top test failed");
        $finish;
    end

    // Map a speed setting to the inverted drive value
    function automatic logic [dcm_pkg::DRIVE_W-1:0] drive_for(input logic [9:0] s);
        int v;
        if (s > cfg.high_cut)
            return dcm_pkg::DRIVE_FULL;
        if (s < cfg.low_cut)
            return dcm_pkg::DRIVE_OFF;
        v = 500 - (500 * int'(s)) / FULL_SCALE;
        return v[dcm_pkg::DRIVE_W-1:0];
    endfunction

    // Advance the motor model by one command and return its result
    function automatic drive_res_t motor_step(input motor_cmd_t c);
        drive_res_t                r;
        logic [dcm_pkg::NOW_W-1:0] elapsed;
        logic                      dreq;
        int                        lvl;
        r       = '0;
        elapsed = c.now_ms - wait_start;
        dreq    = c.dir_value;
        lvl     = int'(speed_level);
        case (c.op)
            dcm_pkg::OP_TICK:
            begin
                case (mot_mode)
                    dcm_pkg::MODE_RUNNING:
                    begin
                        if (!run_en)
                        begin
                            r.speed_write = 1'b1;
                            r.speed_drive = dcm_pkg::DRIVE_OFF;
                            mot_mode      = dcm_pkg::MODE_OFF;
                        end
                        else if (upd_pending)
                        begin
                            upd_pending   = 1'b0;
                            r.speed_write = 1'b1;
                            r.speed_drive = drive_for(speed_level);
                        end
                    end
                    dcm_pkg::MODE_OFF:
                    begin
                        if (run_en)
                        begin
                            r.speed_write = 1'b1;
                            r.speed_drive = drive_for(speed_level);
                            mot_mode      = dcm_pkg::MODE_RUNNING;
                        end
                    end
                    dcm_pkg::MODE_WAIT_OFF:
                    begin
                        if (elapsed > cfg.wait_ms)
                        begin
                            r.dir_write = 1'b1;
                            r.dir_drive = direction;
                            wait_start  = c.now_ms;
                            mot_mode    = dcm_pkg::MODE_WAIT_DIR;
                        end
                    end
                    default:
                    begin
                        if (elapsed > cfg.wait_ms)
                            mot_mode = dcm_pkg::MODE_OFF;
                    end
                endcase
            end
            dcm_pkg::OP_SET_SPEED:
            begin
                // raw request compare: a clamped request may still flag an update
                if ({6'd0, speed_level} != c.speed_value)
                begin
                    lvl = (c.speed_value > FULL_SCALE) ? FULL_SCALE : int'(c.speed_value);
                    speed_level = lvl[9:0];
                    upd_pending = 1'b1;
                end
            end
            dcm_pkg::OP_ACCEL:
            begin
                if (lvl < FULL_SCALE)
                begin
                    lvl = lvl + int'(cfg.speed_step);
                    if (lvl > FULL_SCALE)
                        lvl = FULL_SCALE;
                    speed_level = lvl[9:0];
                    upd_pending = 1'b1;
                end
            end
            dcm_pkg::OP_SLOW:
            begin
                if (lvl > 0)
                begin
                    lvl = (lvl > int'(cfg.speed_step)) ? lvl - int'(cfg.speed_step) : 0;
                    speed_level = lvl[9:0];
                    upd_pending = 1'b1;
                end
            end
            dcm_pkg::OP_STOP: run_en = 1'b0;
            dcm_pkg::OP_RUN:  run_en = 1'b1;
            default:
            begin
                if (c.op == dcm_pkg::OP_TOGGLE_DIR)
                    dreq = ~direction;
                if (dreq != direction)
                begin
                    r.speed_write = 1'b1;
                    r.speed_drive = dcm_pkg::DRIVE_OFF;
                    mot_mode      = dcm_pkg::MODE_WAIT_OFF;
                    direction     = dreq;
                    wait_start    = c.now_ms;
                end
            end
        endcase
        r.motor_mode    = mot_mode;
        r.speed_setting = speed_level;
        return r;
    endfunction

    // Draw a random command; time mostly creeps forward, sometimes jumps
    function automatic motor_cmd_t random_cmd();
        motor_cmd_t c;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      c.op = dcm_pkg::OP_TICK;
        else if (pick < 55) c.op = dcm_pkg::OP_SET_SPEED;
        else if (pick < 63) c.op = dcm_pkg::OP_ACCEL;
        else if (pick < 71) c.op = dcm_pkg::OP_SLOW;
        else if (pick < 76) c.op = dcm_pkg::OP_STOP;
        else if (pick < 83) c.op = dcm_pkg::OP_RUN;
        else if (pick < 93) c.op = dcm_pkg::OP_SET_DIR;
        else                c.op = dcm_pkg::OP_TOGGLE_DIR;

        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            c.speed_value = dcm_pkg::REQ_W'($urandom_range(0, 65535));
        end
        else if (pick < 75)
        begin
            c.speed_value = dcm_pkg::REQ_W'($urandom_range(0, FULL_SCALE));
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 5))
                0:       c.speed_value = '0;
                1:       c.speed_value = dcm_pkg::REQ_W'(FULL_SCALE);
                2:       c.speed_value = dcm_pkg::REQ_W'(FULL_SCALE + 1);
                3:       c.speed_value = '1;
                4:       c.speed_value = dcm_pkg::REQ_W'(cfg.low_cut);
                default: c.speed_value = dcm_pkg::REQ_W'(cfg.high_cut) + 1'b1;
            endcase
        end
        else
        begin
            c.speed_value = dcm_pkg::REQ_W'(speed_level);
        end
        c.dir_value = 1'($urandom_range(0, 1));

        pick = $urandom_range(0, 99);
        if (pick < 60)
            ms_clock = ms_clock + $urandom_range(0, 2);
        else if (pick < 90)
            ms_clock = ms_clock + $urandom_range(0, int'(cfg.wait_ms) + 3);
        else if (pick < 98)
            ms_clock = ms_clock + $urandom_range(0, 600);
        else
            ms_clock = $urandom;
        c.now_ms = ms_clock;
        return c;
    endfunction

    task automatic add_row(input dcm_pkg::op_t op, input int sv, input bit dv,
                           input logic [31:0] now, input bit fixed, input drive_res_t r);
        cmd_row_t row;
        row.cmd.op          = op;
        row.cmd.speed_value = dcm_pkg::REQ_W'(sv);
        row.cmd.dir_value   = dv;
        row.cmd.now_ms      = now;
        row.fixed           = fixed;
        row.res             = r;
        cmd_table.push_back(row);
    endtask

    // Sender pacing: bursts of random length separated by random gaps unless gapless
    task automatic pace();
        if (burst_left == 0)
        begin
            if (!gapless)
            begin
                cmd.valid <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            end
            burst_left = $urandom_range(1, MAX_BURST);
        end
        burst_left--;
    endtask

    // Offer one command beat and record its result when it is taken
    task automatic send_cmd(input motor_cmd_t c, input bit fixed, input drive_res_t fixed_res);
        drive_res_t r;
        cmd.valid       <= 1'b1;
        cmd.op          <= c.op;
        cmd.speed_value <= c.speed_value;
        cmd.dir_value   <= c.dir_value;
        cmd.now_ms      <= c.now_ms;
        @(posedge clk);
        while (cmd.ready !== 1'b1) @(posedge clk);
        r = motor_step(c);
        if (fixed)
            r = fixed_res;
        drive_q.push_back(r);
    endtask

    // Drop valid and wait for all outstanding results
    task automatic drain();
        cmd.valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [dcm_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dcm_pkg::REG_SPEED_STEP: cfg.speed_step = val[dcm_pkg::STEP_W-1:0];
            dcm_pkg::REG_LOW_CUT:    cfg.low_cut    = val[dcm_pkg::CUT_W-1:0];
            dcm_pkg::REG_HIGH_CUT:   cfg.high_cut   = val[dcm_pkg::CUT_W-1:0];
            default:                 cfg.wait_ms    = val[dcm_pkg::WAIT_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic load_config(input int step, input int low, input int high, input int wms);
        cfg_write(dcm_pkg::REG_SPEED_STEP, 32'(step));
        cfg_write(dcm_pkg::REG_LOW_CUT, 32'(low));
        cfg_write(dcm_pkg::REG_HIGH_CUT, 32'(high));
        cfg_write(dcm_pkg::REG_WAIT_MS, 32'(wms));
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        drive_res_t want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            if (drive_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing pending, expected none, got mode %0d",
                         $time, res.motor_mode);
            end
            else
            begin
                want = drive_q.pop_front();
                check_field("speed_write", 32'(want.speed_write), 32'(res.speed_write));
                check_field("speed_drive", 32'(want.speed_drive), 32'(res.speed_drive));
                check_field("dir_write", 32'(want.dir_write), 32'(res.dir_write));
                check_field("dir_drive", 32'(want.dir_drive), 32'(res.dir_drive));
                check_field("motor_mode", 32'(want.motor_mode), 32'(res.motor_mode));
                check_field("speed_setting", 32'(want.speed_setting), 32'(res.speed_setting));
            end
        end
    end

    // Result receiver: stall styles in segments, plus long hold-offs on request
    initial
    begin : result_sink
        int seg_left;
        int style;
        int hold_left;
        seg_left  = 0;
        style     = SINK_OPEN;
        hold_left = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else if (holds_taken != holds_asked)
            begin
                holds_taken++;
                hold_left = LONG_HOLD - 1;
                res.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style    = $urandom_range(SINK_OPEN, SINK_TOGGLE);
                    seg_left = $urandom_range(1, 40);
                end
                seg_left--;
                case (style)
                    SINK_OPEN:   res.ready <= 1'b1;
                    SINK_MOSTLY: res.ready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
                    default:     res.ready <= ~res.ready;
                endcase
            end
        end
    end

    // Main sequence
    initial
    begin
        drive_res_t none;
        drive_res_t r;
        motor_cmd_t c;
        int         p;
        none            = '0;
        mismatches      = 0;
        holds_asked     = 0;
        holds_taken     = 0;
        burst_left      = 0;
        gapless         = 1'b0;
        ms_clock        = '0;
        cfg.speed_step  = dcm_pkg::RST_SPEED_STEP;
        cfg.low_cut     = dcm_pkg::RST_LOW_CUT;
        cfg.high_cut    = dcm_pkg::RST_HIGH_CUT;
        cfg.wait_ms     = dcm_pkg::RST_WAIT_MS;
        mot_mode        = dcm_pkg::MODE_RUNNING;
        speed_level     = '0;
        upd_pending     = 1'b1;
        run_en          = 1'b1;
        direction       = 1'b0;
        wait_start      = '0;

        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cmd.valid       <= 1'b0;
        cmd.op          <= '0;
        cmd.speed_value <= '0;
        cmd.dir_value   <= 1'b0;
        cmd.now_ms      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings
        r = '{1'b1, dcm_pkg::DRIVE_OFF, 1'b0, 1'b0, dcm_pkg::MODE_RUNNING, 10'd0};
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b1, r);
        r = '{1'b0, 9'd0, 1'b0, 1'b0, dcm_pkg::MODE_RUNNING, 10'd0};
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd1, 1'b1, r);
        r = '{1'b0, 9'd0, 1'b0, 1'b0, dcm_pkg::MODE_RUNNING, 10'd1000};
        add_row(dcm_pkg::OP_SET_SPEED, 65535, 1'b1, 32'd1, 1'b1, r);
        r = '{1'b1, dcm_pkg::DRIVE_FULL, 1'b0, 1'b0, dcm_pkg::MODE_RUNNING, 10'd1000};
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd2, 1'b1, r);
        r = '{1'b0, 9'd0, 1'b0, 1'b0, dcm_pkg::MODE_RUNNING, 10'd1000};
        add_row(dcm_pkg::OP_ACCEL, 0, 1'b0, 32'd2, 1'b1, r);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd3, 1'b1, r);
        // clamped request equal to the setting still flags an update
        add_row(dcm_pkg::OP_SET_SPEED, 1001, 1'b0, 32'd3, 1'b0, none);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd4, 1'b0, none);
        add_row(dcm_pkg::OP_SET_SPEED, 0, 1'b0, 32'd4, 1'b0, none);
        r = '{1'b0, 9'd0, 1'b0, 1'b0, dcm_pkg::MODE_RUNNING, 10'd0};
        add_row(dcm_pkg::OP_SLOW, 0, 1'b0, 32'd4, 1'b1, r);
        add_row(dcm_pkg::OP_SET_SPEED, 500, 1'b0, 32'd4, 1'b0, none);
        add_row(dcm_pkg::OP_ACCEL, 0, 1'b0, 32'd4, 1'b0, none);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd5, 1'b0, none);
        add_row(dcm_pkg::OP_STOP, 0, 1'b0, 32'd5, 1'b0, none);
        r = '{1'b1, dcm_pkg::DRIVE_OFF, 1'b0, 1'b0, dcm_pkg::MODE_OFF, 10'd510};
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd6, 1'b1, r);
        add_row(dcm_pkg::OP_RUN, 0, 1'b0, 32'd6, 1'b0, none);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd7, 1'b0, none);
        // same direction is a no-op; reversal straddles the time wrap
        add_row(dcm_pkg::OP_SET_DIR, 0, 1'b0, 32'd7, 1'b0, none);
        r = '{1'b1, dcm_pkg::DRIVE_OFF, 1'b0, 1'b0, dcm_pkg::MODE_WAIT_OFF, 10'd510};
        add_row(dcm_pkg::OP_SET_DIR, 0, 1'b1, 32'hFFFF_FFFE, 1'b1, r);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0, none);
        add_row(dcm_pkg::OP_ACCEL, 0, 1'b0, 32'd0, 1'b0, none);
        r = '{1'b0, 9'd0, 1'b1, 1'b1, dcm_pkg::MODE_WAIT_DIR, 10'd520};
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'd1, 1'b1, r);
        // reversal while already waiting restarts the wait
        add_row(dcm_pkg::OP_TOGGLE_DIR, 0, 1'b0, 32'd2, 1'b0, none);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'h8000_0000, 1'b0, none);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'h8000_0003, 1'b0, none);
        add_row(dcm_pkg::OP_TICK, 0, 1'b0, 32'h8000_0004, 1'b0, none);

        foreach (cmd_table[i])
        begin
            pace();
            send_cmd(cmd_table[i].cmd, cmd_table[i].fixed, cmd_table[i].res);
        end
        drain();

        // Random phases, each under its own register setting
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: load_config(dcm_pkg::RST_SPEED_STEP, dcm_pkg::RST_LOW_CUT,
                               dcm_pkg::RST_HIGH_CUT, dcm_pkg::RST_WAIT_MS);
                1: load_config(0, 0, 1023, 0);
                2: load_config(127, 1023, 0, 255);
                3: load_config(1, 0, 0, 1);
                4: load_config(100, 1000, 1000, 5);
                default: load_config($urandom_range(0, 127), $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 40));
            endcase
            ms_clock = (p == 2) ? 32'hFFFF_FF80 : $urandom;
            gapless  = (p == 3);
            // hold the receiver off while the sender keeps pushing
            if (p == 3)
                holds_asked++;
            for (int n = 0; n < PHASE_CMDS; n++)
            begin
                pace();
                c = random_cmd();
                send_cmd(c, 1'b0, none);
            end
            drain();
        end

        cmd.valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && drive_q.size() == 0)
            $display("dc_motor_speed_reversal_control_top test passed");
        else
            $display("dc_motor_speed_reversal_control_top test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/dcm_pkg.sv
hdl/dcm_cmd_if.sv
hdl/dcm_res_if.sv
hdl/dcm_apb_regs.sv
hdl/dcm_drive_map.sv
hdl/dc_motor_speed_reversal_control_top.sv
verif/tb_top.sv
